/* rtl/core/lru_cache_hit_tracker_defines.svh */
// Assertion macros shared by the checker of the LRU hit tracker.
// Every macro samples on clk and is disabled while rst is high.
`ifndef LRU_CACHE_HIT_TRACKER_DEFINES_SVH
`define LRU_CACHE_HIT_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRUHT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRUHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lruht_pkg.sv */
// Shared types and constants for the LRU hit tracker.
// No dependencies; used by the controller, the datapath and the top level.
package lruht_pkg;

  // Fixed widths of the port fields.
  localparam int KEY_W = 64;
  localparam int CAP_W = 5;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_KEY_BITS    = 64;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_HOLD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_input;
    logic lookup;
    logic update;
    logic load_output;
  } cmd_t;

endpackage

/* rtl/core/lru_cache_hit_tracker.sv */
// Fully associative LRU hit tracker. Each input beat carries one key and yields one
// result beat saying whether the key was held; a miss inserts it, evicting the least
// recently used key once the configured capacity is reached. Each item passes a parallel
// tag compare and then a rank update; while the output drains freely the next key is taken
// during the update of the last one, not before it, and a stalled output holds the block
// after its update until the result register frees. A capacity write empties
// the store and must only be issued while the block is idle.
// Depends on lruht_pkg, lruht_ctrl and lruht_dp.
module lru_cache_hit_tracker #(
  parameter int MAX_ENTRIES = lruht_pkg::DEF_MAX_ENTRIES,
  parameter int KEY_BITS    = lruht_pkg::DEF_KEY_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [lruht_pkg::CAP_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lruht_pkg::KEY_W-1:0] access_key,
  input  logic                        last_of_history,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        hit,
  output logic                        last_out
);

  lruht_pkg::cmd_t cmd;

  // Sequencer.
  lruht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Tag store and result datapath.
  lruht_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .access_key      (access_key),
    .last_of_history (last_of_history),
    .cmd             (cmd),
    .hit             (hit),
    .last_out        (last_out)
  );

endmodule

/* rtl/core/lruht_ctrl.sv */
// Controller of the LRU hit tracker: sequences lookup, update and result hand-off.
// Depends on lruht_pkg for the state and command types.
module lruht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output lruht_pkg::cmd_t   cmd
);

  lruht_pkg::state_t state;
  lruht_pkg::state_t state_next;
  logic              out_free;

  // The result register can take a new beat when empty or being drained.
  assign out_free = !out_valid || !out_stall;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lruht_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next      = state;
    in_stall        = 1'b1;
    cmd.load_input  = 1'b0;
    cmd.lookup      = 1'b0;
    cmd.update      = 1'b0;
    cmd.load_output = 1'b0;
    unique case (state)
      lruht_pkg::ST_IDLE: begin
        in_stall = rst;
        if (in_valid && !rst) begin
          cmd.load_input = 1'b1;
          state_next     = lruht_pkg::ST_LOOKUP;
        end
      end
      lruht_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = lruht_pkg::ST_UPDATE;
      end
      lruht_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        if (out_free) begin
          // Hand the result over and take the next beat in the same cycle.
          cmd.load_output = 1'b1;
          in_stall        = 1'b0;
          if (in_valid) begin
            cmd.load_input = 1'b1;
            state_next     = lruht_pkg::ST_LOOKUP;
          end else begin
            state_next = lruht_pkg::ST_IDLE;
          end
        end else begin
          state_next = lruht_pkg::ST_HOLD;
        end
      end
      lruht_pkg::ST_HOLD: begin
        if (out_free) begin
          cmd.load_output = 1'b1;
          state_next      = lruht_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lruht_pkg::ST_IDLE;
      end
    endcase
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_output) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/core/lruht_dp.sv */
// Datapath of the LRU hit tracker: tag store, recency ranks, compare and result register.
// Depends on lruht_pkg for widths, the capacity reset value and the command type.
module lruht_dp #(
  parameter int MAX_ENTRIES = lruht_pkg::DEF_MAX_ENTRIES,
  parameter int KEY_BITS    = lruht_pkg::DEF_KEY_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [lruht_pkg::CAP_W-1:0] cfg_wr_data,
  input  logic [lruht_pkg::KEY_W-1:0] access_key,
  input  logic                        last_of_history,
  input  lruht_pkg::cmd_t             cmd,
  output logic                        hit,
  output logic                        last_out
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int AGE_W = IDX_W;
  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (OCC_W > lruht_pkg::CAP_W) ? OCC_W : lruht_pkg::CAP_W;

  // Stored state.
  logic [KEY_BITS-1:0]         entry_keys [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]      entry_valid;
  logic [AGE_W-1:0]            entry_age  [MAX_ENTRIES];
  logic [OCC_W-1:0]            occupancy;
  logic [lruht_pkg::CAP_W-1:0] capacity;

  // Current beat and lookup decision.
  logic [KEY_BITS-1:0]         cur_key;
  logic                        cur_last;
  logic                        res_hit;
  logic [IDX_W-1:0]            slot;
  logic [AGE_W-1:0]            limit;
  logic                        fill;

  // Lookup logic.
  logic [MAX_ENTRIES-1:0]      match;
  logic [IDX_W-1:0]            hit_idx;
  logic [IDX_W-1:0]            free_idx;
  logic [IDX_W-1:0]            victim_idx;
  logic [OCC_W-1:0]            occ_m1;
  logic [CMP_W-1:0]            cap_wide;
  logic [OCC_W-1:0]            live_cap;
  logic                        any_hit;
  logic                        has_room;

  // Effective capacity: zero means one, large values saturate to the store size.
  always_comb begin
    cap_wide = CMP_W'(capacity);
    if (cap_wide == '0) begin
      live_cap = OCC_W'(1);
    end else if (cap_wide > CMP_W'(MAX_ENTRIES)) begin
      live_cap = OCC_W'(MAX_ENTRIES);
    end else begin
      live_cap = cap_wide[OCC_W-1:0];
    end
  end

  assign has_room = occupancy < live_cap;
  assign occ_m1   = occupancy - OCC_W'(1);

  // Parallel compare across all entries; lowest index wins each search.
  // Valid ranks are distinct, so the victim is the entry ranked occupancy minus one.
  always_comb begin
    match      = '0;
    hit_idx    = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      match[i] = entry_valid[i] && (entry_keys[i] == cur_key);
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        free_idx = IDX_W'(i);
      end
      if (entry_valid[i] && (OCC_W'(entry_age[i]) == occ_m1)) begin
        victim_idx = IDX_W'(i);
      end
    end
  end

  assign any_hit = |match;

  // Input beat capture.
  always_ff @(posedge clk) begin
    if (cmd.load_input) begin
      cur_key  <= access_key[KEY_BITS-1:0];
      cur_last <= last_of_history;
    end
  end

  // Lookup decision register.
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      res_hit <= any_hit;
      fill    <= !any_hit && has_room;
      if (any_hit) begin
        slot  <= hit_idx;
        limit <= entry_age[hit_idx];
      end else if (has_room) begin
        slot  <= free_idx;
        limit <= entry_age[victim_idx];
      end else begin
        slot  <= victim_idx;
        limit <= entry_age[victim_idx];
      end
    end
  end

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lruht_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // Valid marks, ranks and occupancy; a capacity write empties the store.
  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      entry_valid <= '0;
      occupancy   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        entry_age[i] <= '0;
      end
    end else if (cmd.update) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (IDX_W'(i) == slot) begin
          entry_valid[i] <= 1'b1;
          entry_age[i]   <= '0;
        end else if (entry_valid[i] && (fill || (entry_age[i] < limit))) begin
          entry_age[i] <= entry_age[i] + AGE_W'(1);
        end
      end
      if (fill) begin
        occupancy <= occupancy + OCC_W'(1);
      end
    end
  end

  // Tag write on a miss.
  always_ff @(posedge clk) begin
    if (cmd.update && !res_hit) begin
      entry_keys[slot] <= cur_key;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_output) begin
      hit      <= res_hit;
      last_out <= cur_last;
    end
  end

endmodule

/* rtl/core/lruht_checker.sv */
// Port-level checker for the LRU hit tracker, bound to the top level.
// Depends on lru_cache_hit_tracker_defines.svh for the assertion macros.
`include "lru_cache_hit_tracker_defines.svh"

module lruht_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic hit,
  input logic last_out
);

  // A stalled result beat keeps its payload.
  `LRUHT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                     out_valid && $stable(hit) && $stable(last_out),
                     "stalled result beat changed")

  // The block is busy in the cycle after taking a beat.
  `LRUHT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
                     "input accepted during lookup")

  // Every accepted beat has a result on offer once its lookup and update have passed.
  `LRUHT_ASSERT_SAME(a_result_follows, in_valid && !in_stall, ##3 out_valid,
                     "result beat missing after accept")

  // A result only appears after a lookup cycle.
  `LRUHT_ASSERT_SAME(a_no_spurious_result, $rose(out_valid), $past(in_stall, 2),
                     "result beat without a lookup")

endmodule

bind lru_cache_hit_tracker lruht_checker u_checker (.*);

/* test/lru_cache_hit_tracker_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for lru_cache_hit_tracker: a directed table, then random key streams.
// Every result beat is checked against a typed table value or a recency-ordered store model kept here.
// Depends on lruht_pkg and the lru_cache_hit_tracker RTL.
module lru_cache_hit_tracker_test;

  localparam int STORE_DEPTH = lruht_pkg::DEF_MAX_ENTRIES;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS = 150;

  typedef enum logic {ROW_ACCESS, ROW_CAPACITY} row_kind_t;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [lruht_pkg::KEY_W-1:0] key;
    logic                        last;
    logic [lruht_pkg::CAP_W-1:0] cap;
    logic                        typed;
    logic                        typed_hit;
  } stim_row_t;

  typedef struct packed {
    logic hit;
    logic last;
  } lookup_result_t;

  localparam logic [lruht_pkg::KEY_W-1:0] KEY_A = 64'h0123_4567_89AB_CDEF;
  localparam logic [lruht_pkg::KEY_W-1:0] KEY_B = KEY_A ^ 64'h1;
  localparam logic [lruht_pkg::KEY_W-1:0] KEY_C = KEY_A ^ 64'h8000_0000_0000_0000;
  localparam logic [lruht_pkg::KEY_W-1:0] KEY_ONES = '1;

  // Directed rows: typed results where the outcome is obvious, the model decides the rest.
  stim_row_t directed_rows [0:25] = '{
    '{ROW_ACCESS,   64'h0,    1'b0, 5'd0,  1'b1, 1'b0},
    '{ROW_ACCESS,   64'h0,    1'b1, 5'd0,  1'b1, 1'b1},
    '{ROW_ACCESS,   KEY_ONES, 1'b0, 5'd0,  1'b1, 1'b0},
    '{ROW_ACCESS,   KEY_ONES, 1'b1, 5'd0,  1'b1, 1'b1},
    '{ROW_ACCESS,   64'h0,    1'b0, 5'd0,  1'b1, 1'b1},
    '{ROW_CAPACITY, 64'h0,    1'b0, 5'd1,  1'b0, 1'b0},
    '{ROW_ACCESS,   KEY_A,    1'b0, 5'd0,  1'b1, 1'b0},
    '{ROW_ACCESS,   KEY_A,    1'b0, 5'd0,  1'b1, 1'b1},
    '{ROW_ACCESS,   KEY_B,    1'b0, 5'd0,  1'b1, 1'b0},
    '{ROW_ACCESS,   KEY_A,    1'b1, 5'd0,  1'b1, 1'b0},
    '{ROW_CAPACITY, 64'h0,    1'b0, 5'd0,  1'b0, 1'b0},
    '{ROW_ACCESS,   KEY_C,    1'b0, 5'd0,  1'b1, 1'b0},
    '{ROW_ACCESS,   KEY_C,    1'b0, 5'd0,  1'b1, 1'b1},
    '{ROW_ACCESS,   KEY_A,    1'b0, 5'd0,  1'b1, 1'b0},
    '{ROW_ACCESS,   KEY_C,    1'b0, 5'd0,  1'b1, 1'b0},
    '{ROW_CAPACITY, 64'h0,    1'b0, 5'd2,  1'b0, 1'b0},
    '{ROW_ACCESS,   KEY_A,    1'b0, 5'd0,  1'b0, 1'b0},
    '{ROW_ACCESS,   KEY_B,    1'b0, 5'd0,  1'b0, 1'b0},
    '{ROW_ACCESS,   KEY_A,    1'b0, 5'd0,  1'b0, 1'b0},
    '{ROW_ACCESS,   KEY_C,    1'b0, 5'd0,  1'b0, 1'b0},
    '{ROW_ACCESS,   KEY_B,    1'b0, 5'd0,  1'b0, 1'b0},
    '{ROW_ACCESS,   KEY_A,    1'b1, 5'd0,  1'b0, 1'b0},
    '{ROW_CAPACITY, 64'h0,    1'b0, 5'd31, 1'b0, 1'b0},
    '{ROW_ACCESS,   KEY_A,    1'b0, 5'd0,  1'b1, 1'b0},
    '{ROW_ACCESS,   KEY_A,    1'b1, 5'd0,  1'b1, 1'b1},
    '{ROW_CAPACITY, 64'h0,    1'b0, 5'd16, 1'b0, 1'b0}
  };

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_wr_en = 1'b0;
  logic [lruht_pkg::CAP_W-1:0] cfg_wr_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [lruht_pkg::KEY_W-1:0] access_key = '0;
  logic                        last_of_history = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        hit;
  logic                        last_out;

  // Travels with each beat so that the typed result lines up with its key.
  logic row_typed = 1'b0;
  logic row_typed_hit = 1'b0;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_request = 0;

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned accesses_sent = 0;
  int unsigned results_checked = 0;
  int unsigned hits_seen = 0;
  int unsigned capacity_writes = 0;

  lookup_result_t pending_results [$];

  // Model of the store: tags, valid marks, recency ranks (0 is newest) and fill level.
  logic [lruht_pkg::KEY_W-1:0] held_key   [STORE_DEPTH];
  bit                          held_valid [STORE_DEPTH];
  int unsigned                 held_rank  [STORE_DEPTH];
  int unsigned                 held_count = 0;
  logic [lruht_pkg::CAP_W-1:0] capacity_reg = lruht_pkg::CAP_RESET;

  lru_cache_hit_tracker uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .access_key      (access_key),
    .last_of_history (last_of_history),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .hit             (hit),
    .last_out        (last_out)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // A capacity write empties the store under the new setting.
  function automatic void restart_store(input logic [lruht_pkg::CAP_W-1:0] value);
    capacity_reg = value;
    held_count = 0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      held_valid[i] = 1'b0;
      held_rank[i] = 0;
    end
  endfunction

  function automatic int unsigned usable_entries(input logic [lruht_pkg::CAP_W-1:0] value);
    if (value == 0) return 1;
    if (value > STORE_DEPTH) return STORE_DEPTH;
    return value;
  endfunction

  function automatic void age_entries_below(input int unsigned limit);
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (held_valid[i] && held_rank[i] < limit) held_rank[i]++;
    end
  endfunction

  // Looks the key up, updates recency and insertion, and returns whether it hit.
  function automatic bit track_access(input logic [lruht_pkg::KEY_W-1:0] key);
    int unsigned slot;
    int unsigned oldest;
    bit found;
    slot = STORE_DEPTH;
    oldest = 0;
    found = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (!found && held_valid[i] && held_key[i] == key) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (found) begin
      age_entries_below(held_rank[slot]);
      held_rank[slot] = 0;
    end else if (held_count < usable_entries(capacity_reg)) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        if (slot == STORE_DEPTH && !held_valid[i]) slot = i;
      end
      if (slot < STORE_DEPTH) begin
        age_entries_below(STORE_DEPTH);
        held_valid[slot] = 1'b1;
        held_key[slot] = key;
        held_rank[slot] = 0;
        held_count++;
      end
    end else begin
      // Evict the valid entry with the oldest rank.
      for (int i = 0; i < STORE_DEPTH; i++) begin
        if (held_valid[i] && (slot == STORE_DEPTH || held_rank[i] > oldest)) begin
          slot = i;
          oldest = held_rank[i];
        end
      end
      if (slot < STORE_DEPTH) begin
        age_entries_below(oldest);
        held_key[slot] = key;
        held_rank[slot] = 0;
      end
    end
    return found;
  endfunction

  // Samples every handshake at the clock edge: configuration, accepted keys, result beats.
  always @(posedge clk) begin
    lookup_result_t expected;
    bit predicted;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: run exceeded %0d cycles with %0d results outstanding",
               $time, CYCLE_LIMIT, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (!rst) begin
      if (cfg_wr_en) restart_store(cfg_wr_data);
      if (in_valid && !in_stall) begin
        predicted = track_access(access_key);
        expected.hit = row_typed ? row_typed_hit : predicted;
        expected.last = last_of_history;
        pending_results.insert(pending_results.size(), expected);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: unexpected result beat, expected none, got hit=%b last_out=%b",
                   $time, hit, last_out);
          mismatch_count++;
        end else begin
          expected = pending_results.pop_front();
          results_checked++;
          if (hit === 1'b1) hits_seen++;
          if (hit !== expected.hit) begin
            $display("%0t ns: hit expected %b, got %b", $time, expected.hit, hit);
            mismatch_count++;
          end
          if (last_out !== expected.last) begin
            $display("%0t ns: last_out expected %b, got %b", $time, expected.last, last_out);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off counted out here when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        out_stall <= 1'b1;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Offers one key beat and returns at the edge that accepts it, valid still high.
  task automatic offer_access(input logic [lruht_pkg::KEY_W-1:0] key, input logic last,
                              input logic typed, input logic typed_hit);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    access_key <= key;
    last_of_history <= last;
    row_typed <= typed;
    row_typed_hit <= typed_hit;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    accesses_sent++;
  endtask

  // The register is only written once every result has drained; the extra edge lets the
  // monitor record a beat accepted at the edge this task was entered on.
  task automatic write_capacity(input logic [lruht_pkg::CAP_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    capacity_writes++;
  endtask

  function automatic void set_idling(input idle_mode_t mode);
    idle_pct = (mode == IDLE_SENDER) ? 47 : (mode == IDLE_BOTH) ? 7 : 0;
    stall_pct = (mode == IDLE_RECEIVER) ? 47 : (mode == IDLE_BOTH) ? 7 : 0;
  endfunction

  // Random keys drawn mostly from a pool of the usable capacity plus up to four, so that hits,
  // fills and evictions all occur; some are fresh and some differ from a pooled tag in one bit.
  task automatic run_phase(input logic [lruht_pkg::CAP_W-1:0] cap_value,
                           input idle_mode_t mode, input bit hold_off);
    logic [lruht_pkg::KEY_W-1:0] key_pool [$];
    logic [lruht_pkg::KEY_W-1:0] key;
    int unsigned pool_size;
    int unsigned pick;
    write_capacity(cap_value);
    set_idling(mode);
    if (hold_off) hold_request = HOLD_OFF_CYCLES;
    pool_size = usable_entries(cap_value) + $urandom_range(0, 4);
    for (int i = 0; i < pool_size; i++) begin
      key = {$urandom, $urandom};
      key_pool.insert(key_pool.size(), key);
    end
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      pick = $urandom_range(99);
      key = key_pool[$urandom_range(pool_size - 1)];
      if (pick >= 95) key = key ^ (64'd1 << $urandom_range(lruht_pkg::KEY_W - 1));
      else if (pick >= 80) key = {$urandom, $urandom};
      offer_access(key, $urandom_range(7) == 0, 1'b0, 1'b0);
    end
  endtask

  // Main sequence: reset, directed table, then random phases over several capacities.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(IDLE_NONE);
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CAPACITY) write_capacity(directed_rows[r].cap);
      else offer_access(directed_rows[r].key, directed_rows[r].last,
                        directed_rows[r].typed, directed_rows[r].typed_hit);
    end

    run_phase(5'd16, IDLE_NONE, 1'b1);
    run_phase(5'd1, IDLE_SENDER, 1'b0);
    run_phase(5'd0, IDLE_RECEIVER, 1'b0);
    run_phase(5'd31, IDLE_BOTH, 1'b0);
    run_phase(5'd17, IDLE_NONE, 1'b1);
    run_phase(5'd2, IDLE_SENDER, 1'b0);
    run_phase(5'd5, IDLE_RECEIVER, 1'b0);
    run_phase(5'd15, IDLE_BOTH, 1'b0);
    run_phase(lruht_pkg::CAP_W'($urandom_range(0, 31)), IDLE_NONE, 1'b0);

    // Drain, then allow a short window for any stray beats.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d key accesses over %0d capacity settings, four idling patterns",
             accesses_sent, capacity_writes);
    $display("and two long output hold-offs; %0d results checked, %0d of them hits.",
             results_checked, hits_seen);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
